### rtl/v3g_pkg.sv
// Package for the 3D vector geometry unit: request and result structs, opcodes,
// status codes and the divider depth. No dependencies.
`default_nettype none
package v3g_pkg;

  // Quotient bits resolved by the divider pipeline, one per stage.
  localparam int unsigned DivStages = 34;

  typedef enum logic [2:0] {
    FUNC_DOT   = 3'd0,
    FUNC_CROSS = 3'd1,
    FUNC_LEN   = 3'd2,
    FUNC_NORM  = 3'd3,
    FUNC_SCALE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic signed [31:0] target_len;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic [1:0]         status;
  } res_t;

  // Saturate a signed value of up to 67 bits to the signed 32-bit range.
  function automatic logic [32:0] sat32(input logic signed [66:0] v);
    logic [32:0] r;
    if (v > 67'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -67'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/v3g_lane.sv
// One product lane: given the two components it owns, it forms their signed
// product, as dot and cross need. Depends on v3g_pkg.
`default_nettype none
module v3g_lane
  import v3g_pkg::*;
(
  input  logic signed [31:0] p_i,
  input  logic signed [31:0] q_i,
  output logic signed [63:0] prod_o
);
  assign prod_o = 64'(p_i) * 64'(q_i);
endmodule
`default_nettype wire

### rtl/v3g_sqrt.sv
// Pipelined restoring square root, one result bit per stage, 64-bit radicand.
// A side payload travels along with each radicand. Depends on v3g_pkg.
`default_nettype none
module v3g_sqrt
  import v3g_pkg::*;
#(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [63:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [31:0]      root_o,
  output logic [64:0]      rem_o,
  output logic [SideW-1:0] side_o
);
  localparam int unsigned Steps = 32;

  logic [Steps:0]       vld_q;
  logic [64:0]          rem_q  [Steps+1];
  logic [31:0]          root_q [Steps+1];
  logic [63:0]          rad_q  [Steps+1];
  logic [SideW-1:0]     side_q [Steps+1];

  always_comb begin
    rem_q[0]  = '0;
    root_q[0] = '0;
    rad_q[0]  = rad_i;
    side_q[0] = side_i;
  end
  assign vld_q[0] = vld_i;

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [64:0] rem_d;
    logic [64:0] trial;
    logic [31:0] root_d;
    always_comb begin
      rem_d  = {rem_q[s][62:0], rad_q[s][63:62]};
      trial  = {31'b0, root_q[s], 2'b01};
      root_d = {root_q[s][30:0], 1'b0};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_q[s][30:0], 1'b1};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        rad_q[s+1]  <= {rad_q[s][61:0], 2'b00};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign vld_o  = vld_q[Steps];
  assign root_o = root_q[Steps];
  assign rem_o  = rem_q[Steps];
  assign side_o = side_q[Steps];
endmodule
`default_nettype wire

### rtl/v3g_div.sv
// Pipelined unsigned restoring divider: 64-bit numerator over 32-bit divisor,
// quotient clamped to 33 bits. Inputs are registered first, then one quotient
// bit per stage. Depends on v3g_pkg.
`default_nettype none
module v3g_div
  import v3g_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [32:0] quo_o
);
  // Quotients beyond 2^32 clamp; only 34 quotient bits are needed with an
  // overflow flag for the rest.
  localparam int unsigned QBits = DivStages;

  logic [63:0] num_in_q;
  logic [31:0] den_in_q;
  logic [31:0] hi_ovf;
  logic [31:0] rem_q  [QBits+1];
  logic [QBits-1:0] quo_q [QBits+1];
  logic [QBits-1:0] num_q [QBits+1];
  logic [31:0] den_q  [QBits+1];
  logic        ovf_q  [QBits+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_in_q <= num_i;
      den_in_q <= den_i;
    end
  end

  // Upper 30 numerator bits must be below the divisor for a 34-bit quotient.
  assign hi_ovf = 32'(num_in_q[63:QBits]);
  always_comb begin
    rem_q[0] = hi_ovf;
    quo_q[0] = '0;
    num_q[0] = num_in_q[QBits-1:0];
    den_q[0] = den_in_q;
    ovf_q[0] = (hi_ovf >= den_in_q);
  end

  for (genvar s = 0; s < QBits; s++) begin : g_stage
    logic [32:0] part;
    logic [31:0] rem_d;
    logic        bit_d;
    always_comb begin
      part  = {rem_q[s], num_q[s][QBits-1]};
      bit_d = (part >= {1'b0, den_q[s]});
      rem_d = bit_d ? 32'(part - {1'b0, den_q[s]}) : part[31:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        quo_q[s+1] <= {quo_q[s][QBits-2:0], bit_d};
        num_q[s+1] <= {num_q[s][QBits-2:0], 1'b0};
        den_q[s+1] <= den_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  always_comb begin
    if (ovf_q[QBits] || quo_q[QBits][QBits-1]) begin
      quo_o = {1'b1, 32'b0};
    end else if (quo_q[QBits][32] && (quo_q[QBits][31:0] != '0)) begin
      quo_o = {1'b1, 32'b0};
    end else begin
      quo_o = quo_q[QBits][32:0];
    end
  end
endmodule
`default_nettype wire

### rtl/vector3_geometry_unit.sv
// Top level of the 3D vector geometry unit: nine product lanes, a square
// root pipeline and three divider lanes, merged into one result register.
// Depends on v3g_pkg, v3g_lane, v3g_sqrt and v3g_div.
//
//   channel | direction | handshake            | payload
//   request | in        | req_valid_i/ready_o  | req_i  (req_t)
//   result  | out       | res_valid_o/ready_i  | res_o  (res_t)
//
// One request is taken per cycle while the pipeline advances. Every request
// walks the same pipeline: a stage of magnitudes, normalizing shift and lane
// products, a stage of squares, sums and rounding, 32 square-root stages, a
// divider input register and 34 divider stages, then the output register.
// The pipeline advances only while the output register is free or is taken,
// so a stalled result holds every stage. No state survives a request.
`default_nettype none
module vector3_geometry_unit
  import v3g_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);
  // The divider registers its inputs before the quotient stages.
  localparam int unsigned DivLat = DivStages + 1;

  logic en;
  assign en = !res_valid_o || res_ready_i;
  assign req_ready_o = en;

  // ---------------- stage 1: magnitudes, normalizing shift, products
  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic [31:0] m [3];
  logic [31:0] mx;
  logic [4:0]  shamt;
  logic [31:0] mn [3];
  logic [31:0] sel [3];
  logic signed [63:0] pa [3], pb [3], pc [3];
  logic [63:0] psq [3];

  always_comb begin
    a[0] = req_i.vec_a_x; a[1] = req_i.vec_a_y; a[2] = req_i.vec_a_z;
    b[0] = req_i.vec_b_x; b[1] = req_i.vec_b_y; b[2] = req_i.vec_b_z;
    for (int i = 0; i < 3; i++) begin
      m[i] = a[i][31] ? 32'(-a[i]) : a[i];
    end
    mx = m[0] | m[1] | m[2];
    shamt = '0;
    for (int k = 31; k >= 0; k--) begin
      if (mx[k] && shamt == '0 && k < 30) begin
        shamt = 5'(30 - k);
      end
    end
    if (mx[31] || mx[30]) shamt = '0;
    for (int i = 0; i < 3; i++) begin
      mn[i] = m[i] << shamt;
      // The length path squares raw magnitudes, the norm and scale paths the shifted ones.
      sel[i] = (req_i.func == FUNC_LEN) ? m[i] : mn[i];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3g_lane u_dot (.p_i(a[i]), .q_i(b[i]), .prod_o(pa[i]));
    v3g_lane u_crs (.p_i(a[J]), .q_i(b[K]), .prod_o(pb[i]));
    v3g_lane u_crt (.p_i(a[K]), .q_i(b[J]), .prod_o(pc[i]));
  end

  logic               s1_vld_q;
  logic [2:0]         s1_func_q;
  logic               s1_zero_q;
  logic signed [63:0] s1_pa_q [3], s1_pb_q [3], s1_pc_q [3];
  logic [31:0]        s1_sel_q [3];
  logic [31:0]        s1_mn_q [3];
  logic [2:0]         s1_neg_q;
  logic [31:0]        s1_tm_q;
  logic               s1_tneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q <= req_i.func;
      s1_zero_q <= (mx == '0);
      for (int i = 0; i < 3; i++) begin
        s1_pa_q[i] <= pa[i];
        s1_pb_q[i] <= pb[i];
        s1_pc_q[i] <= pc[i];
        s1_sel_q[i] <= sel[i];
        s1_mn_q[i] <= mn[i];
        s1_neg_q[i] <= a[i][31];
      end
      s1_tm_q   <= req_i.target_len[31] ? 32'(-req_i.target_len) : req_i.target_len;
      s1_tneg_q <= req_i.target_len[31];
    end
  end

  // ---------------- stage 2: squares, sums and rounding of dot and cross
  logic signed [65:0] dot_sum;
  logic signed [65:0] crs_sum [3];
  logic [63:0]        sq_sum;
  logic [32:0]        dot_sat;
  logic [32:0]        crs_sat [3];

  always_comb begin
    dot_sum = 66'(s1_pa_q[0]) + 66'(s1_pa_q[1]) + 66'(s1_pa_q[2]) + 66'sd32768;
    dot_sat = sat32(67'(dot_sum >>> 16));
    for (int i = 0; i < 3; i++) begin
      crs_sum[i] = 66'(s1_pb_q[i]) - 66'(s1_pc_q[i]) + 66'sd32768;
      crs_sat[i] = sat32(67'(crs_sum[i] >>> 16));
      psq[i] = 64'(s1_sel_q[i]) * 64'(s1_sel_q[i]);
    end
  end

  // Side payload carried through the square-root pipeline.
  typedef struct packed {
    logic [2:0]  func;
    logic        zero;
    logic [32:0] r0, r1, r2;
    logic [31:0] m0, m1, m2;
    logic [2:0]  neg;
    logic [31:0] tm;
    logic        tneg;
  } side_t;

  side_t side_in, side_out;
  logic  sq_vld;
  logic [31:0] root;
  logic [64:0] rem;

  always_comb begin
    side_in.func = s1_func_q;
    side_in.zero = s1_zero_q;
    side_in.r0   = (s1_func_q == FUNC_DOT) ? dot_sat : crs_sat[0];
    side_in.r1   = crs_sat[1];
    side_in.r2   = crs_sat[2];
    side_in.m0   = s1_mn_q[0];
    side_in.m1   = s1_mn_q[1];
    side_in.m2   = s1_mn_q[2];
    side_in.neg  = s1_neg_q;
    side_in.tm   = s1_tm_q;
    side_in.tneg = s1_tneg_q;
  end

  logic        s2_vld_q;
  logic [63:0] s2_sq_q [3];
  side_t       s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= side_in;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= psq[i];
      end
    end
  end

  assign sq_sum = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];

  v3g_sqrt #(.SideW($bits(side_t))) u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s2_vld_q), .rad_i(sq_sum), .side_i(s2_side_q),
    .vld_o(sq_vld), .root_o(root), .rem_o(rem), .side_o(side_out)
  );

  // ---------------- division lanes
  logic [63:0] num [3];
  logic [31:0] den;
  logic [32:0] quo [3];
  logic [31:0] mo [3];

  always_comb begin
    mo[0] = side_out.m0; mo[1] = side_out.m1; mo[2] = side_out.m2;
    // A zero vector gives a zero root; divide by one to keep things defined.
    den = (root == '0) ? 32'd1 : root;
    for (int i = 0; i < 3; i++) begin
      num[i] = ((side_out.func == FUNC_NORM) ? {16'b0, mo[i], 16'b0}
                                             : 64'(mo[i]) * 64'(side_out.tm))
               + 64'(root >> 1);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3g_div u_div (.clk_i, .en_i(en), .num_i(num[i]), .den_i(den), .quo_o(quo[i]));
  end

  // Length result: round to nearest, computed before the divider delay.
  logic [32:0] len_r;
  logic [32:0] len_sat;
  always_comb begin
    len_r = {1'b0, root} + 33'(rem > {33'b0, root});
    len_sat = (len_r > 33'h0_7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, len_r[31:0]};
  end

  // Delay line for side data across the divider.
  logic        dl_vld [DivLat+1];
  side_t       dl_side [DivLat+1];
  logic [32:0] dl_len [DivLat+1];
  assign dl_vld[0]  = sq_vld;
  assign dl_side[0] = side_out;
  assign dl_len[0]  = len_sat;

  for (genvar s = 0; s < DivLat; s++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_vld[s+1] <= 1'b0;
      end else if (en) begin
        dl_vld[s+1] <= dl_vld[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_side[s+1] <= dl_side[s];
        dl_len[s+1]  <= dl_len[s];
      end
    end
  end

  // ---------------- merge into the result register
  side_t sd;
  res_t  res_d;
  logic [32:0] nv [3];
  logic        neg_i [3];
  assign sd = dl_side[DivLat];

  always_comb begin
    res_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_i[i] = sd.neg[i] ^ (sd.func == FUNC_SCALE && sd.tneg);
      nv[i] = sat32(neg_i[i] ? -67'(quo[i]) : 67'(quo[i]));
    end
    unique case (sd.func)
      FUNC_DOT: begin
        res_d.res_x  = sd.r0[31:0];
        res_d.status = sd.r0[32] ? ST_SAT : ST_OK;
      end
      FUNC_CROSS: begin
        res_d.res_x  = sd.r0[31:0];
        res_d.res_y  = sd.r1[31:0];
        res_d.res_z  = sd.r2[31:0];
        res_d.status = (sd.r0[32] || sd.r1[32] || sd.r2[32]) ? ST_SAT : ST_OK;
      end
      FUNC_LEN: begin
        res_d.res_x  = dl_len[DivLat][31:0];
        res_d.status = dl_len[DivLat][32] ? ST_SAT : ST_OK;
      end
      FUNC_NORM, FUNC_SCALE: begin
        if (sd.zero) begin
          res_d.status = ST_ZERO;
        end else begin
          res_d.res_x  = nv[0][31:0];
          res_d.res_y  = nv[1][31:0];
          res_d.res_z  = nv[2][31:0];
          res_d.status = (nv[0][32] || nv[1][32] || nv[2][32]) ? ST_SAT : ST_OK;
        end
      end
      default: res_d = '0;
    endcase
  end

  logic res_valid_q;
  res_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= dl_vld[DivLat];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o == (!res_valid_o || res_ready_i))
    else $error("request ready does not follow the result register");
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("stalled result changed");
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status != 2'd3))
    else $error("illegal status code");
`endif
endmodule
`default_nettype wire

### sim/v3g_checker.sv
// Checker for the 3D vector geometry unit: watches both handshake channels,
// computes the expected result of every request and compares them in order.
// Depends on v3g_pkg.
`default_nettype none
module v3g_checker
  import v3g_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   req_valid_i,
  input  logic   req_ready_i,
  input  req_t   req_i,
  input  logic   res_valid_i,
  input  logic   res_ready_i,
  input  res_t   res_i,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t expected_results[$];
  int   reported;

  // Integer square root, floor.
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Clamp to signed 32 bits; sets the flag when clamped.
  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v,
                                                 inout logic flag);
    if (v > 96'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -96'sd2147483648) begin
      flag = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact sum then round half up to Q16.16; >>> on a signed value floors.
  function automatic logic signed [95:0] round_q16(input logic signed [95:0] s);
    return (s + 96'sd32768) >>> 16;
  endfunction

  function automatic res_t compute_geometry(input req_t r);
    res_t o;
    logic signed [95:0] a[3];
    logic signed [95:0] b[3];
    logic signed [95:0] t;
    logic signed [95:0] acc;
    logic [63:0] m[3];
    logic [63:0] s, root, mx, len, tm, num, q;
    logic sat, neg;
    int i;
    o = '0;
    sat = 1'b0;
    a[0] = r.vec_a_x; a[1] = r.vec_a_y; a[2] = r.vec_a_z;
    b[0] = r.vec_b_x; b[1] = r.vec_b_y; b[2] = r.vec_b_z;
    t = r.target_len;
    o.status = ST_OK;
    case (r.func)
      FUNC_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        o.res_x = clamp32(round_q16(acc), sat);
      end
      FUNC_CROSS: begin
        o.res_x = clamp32(round_q16(a[1] * b[2] - a[2] * b[1]), sat);
        o.res_y = clamp32(round_q16(a[2] * b[0] - a[0] * b[2]), sat);
        o.res_z = clamp32(round_q16(a[0] * b[1] - a[1] * b[0]), sat);
      end
      FUNC_LEN: begin
        s = 0;
        for (i = 0; i < 3; i++) begin
          m[i] = a[i] < 0 ? -a[i] : a[i];
          s = s + m[i] * m[i];
        end
        root = isqrt(s);
        if (s - root * root > root) root = root + 1;
        if (root > 64'h7FFF_FFFF) begin
          root = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        o.res_x = root[31:0];
      end
      FUNC_NORM, FUNC_SCALE: begin
        mx = 0;
        tm = t < 0 ? -t : t;
        for (i = 0; i < 3; i++) begin
          m[i] = a[i] < 0 ? -a[i] : a[i];
          if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
          o.status = ST_ZERO;
        end else begin
          while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (i = 0; i < 3; i++) m[i] = m[i] << 1;
          end
          s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
          len = isqrt(s);
          for (i = 0; i < 3; i++) begin
            num = (r.func == FUNC_NORM) ? (m[i] << 16) : (m[i] * tm);
            q = (num + (len >> 1)) / len;
            neg = (a[i] < 0) != (r.func == FUNC_SCALE && t < 0);
            if (q > (64'd1 << 32)) q = 64'd1 << 32;
            acc = {32'd0, q};
            if (neg) acc = -acc;
            case (i)
              0: o.res_x = clamp32(acc, sat);
              1: o.res_y = clamp32(acc, sat);
              default: o.res_z = clamp32(acc, sat);
            endcase
          end
        end
      end
      default: ;
    endcase
    if (o.status == ST_OK && sat) o.status = ST_SAT;
    return o;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      reported = 0;
    end else begin
      if (req_valid_i && req_ready_i) expected_results.push_back(compute_geometry(req_i));
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (reported < 10) $display("unexpected result %h", res_i);
          reported++;
        end else begin
          want = expected_results.pop_front();
          if (want !== res_i) begin
            fail_count_o <= fail_count_o + 1;
            if (reported < 10)
              $display("mismatch: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                       want.res_x, want.res_y, want.res_z, want.status,
                       res_i.res_x, res_i.res_y, res_i.res_z, res_i.status);
            reported++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### sim/testbench.sv
// Top of the geometry unit testbench: clock, reset, request stimulus with
// random idling, random result stalls, and the verdict. Depends on v3g_pkg, v3g_checker and the RTL.
`default_nettype none
module testbench;
  import v3g_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 70;
  localparam int MaxCycles = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  logic calm = 1'b0;

  always #10 clk = ~clk;

  vector3_geometry_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(req_valid), .req_ready_o(req_ready),
    .req_i(req), .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  v3g_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(req_valid), .req_ready_i(req_ready),
    .req_i(req), .res_valid_i(res_valid), .res_ready_i(res_ready), .res_i(res),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) res_ready <= calm || ($urandom_range(99) >= 11);
  end

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(32'h3_FFFF)) - 32'sh2_0000;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Present one request and hold it until accepted, idling first at random.
  task automatic send_request(input req_t r);
    if (!calm && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned func_max);
    req_t r;
    r.func = 3'($urandom_range(func_max));
    r.vec_a_x = rand_comp(); r.vec_a_y = rand_comp(); r.vec_a_z = rand_comp();
    r.vec_b_x = rand_comp(); r.vec_b_y = rand_comp(); r.vec_b_z = rand_comp();
    r.target_len = rand_comp();
    // Some 2D requests.
    if ($urandom_range(3) == 0) begin
      r.vec_a_z = 0;
      r.vec_b_z = 0;
    end
    send_request(r);
  endtask

  task automatic send_fields(input logic [2:0] f, input logic signed [31:0] v,
                             input logic signed [31:0] w, input logic signed [31:0] t);
    req_t r;
    r.func = f;
    r.vec_a_x = v; r.vec_a_y = v; r.vec_a_z = v;
    r.vec_b_x = w; r.vec_b_y = w; r.vec_b_z = w;
    r.target_len = t;
    send_request(r);
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, every operation, zero vectors, unknown opcodes.
    for (n = 0; n < 5; n++) begin
      send_fields(n[2:0], 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
      send_fields(n[2:0], 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_fields(n[2:0], 32'sd0, 32'sh0001_0000, 32'sh0002_0000);
    end
    send_fields(3'd5, 32'sd1, 32'sd1, 32'sd1);
    send_fields(3'd7, -32'sd1, -32'sd1, -32'sd1);
    send_fields(FUNC_NORM, 32'sd1, 32'sd0, 32'sd0);
    send_fields(FUNC_SCALE, -32'sd1, 32'sd0, -32'sh0001_8000);
    // Drain before the random part.
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (n = 0; n < 950; n++) begin
      calm <= (n >= 300 && n < 450);
      send_random(n % 50 == 0 ? 7 : 4);
    end
    req_valid <= 1'b0;
    calm <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("covered all five operations and unknown opcodes over random and extreme");
    $display("vectors, including 2D forms and zero-length normalization");
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
